@@ hw/rtl/aabb_pair_collision_correction_core_assert.svh @@
// Assertion helpers for the collision correction core.
`ifndef AABB_PAIR_COLLISION_CORRECTION_CORE_ASSERT_SVH
`define AABB_PAIR_COLLISION_CORRECTION_CORE_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define AST_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/aabbpc_pkg.sv @@
package aabbpc_pkg;

    localparam int EDGE_W  = 24;
    localparam int SIZE_W  = 23;
    localparam int MASS_W  = 16;
    localparam int SOFT_W  = 12;
    localparam int MOVE_W  = 25;
    localparam int SCALE_W = 16;
    localparam int POS_W   = 26;   // edge plus size, signed
    localparam int MAG_W   = 25;   // push magnitude
    localparam int C_W     = 30;   // scaled push magnitude / quotient
    localparam int PROD_W  = 46;   // push times mass
    localparam int DEN_W   = 17;   // mass sum
    localparam int DIV_LAT = C_W + 1;

    localparam logic [SCALE_W-1:0] SCALE_ONE = 16'd32768;
    localparam logic [SCALE_W-1:0] DIAG_Q15  = 16'd23170;
    localparam logic [DEN_W-1:0]   MASS_ONE  = 17'd256;
    localparam logic [MOVE_W-1:0]  MOVE_MAX  = 25'h0FFFFFF;
    localparam logic [MOVE_W-1:0]  MOVE_MIN  = 25'h1000000;

    typedef enum logic [1:0] {
        NORM_X,
        NORM_Y,
        NORM_DIAG
    } t_norm;

    typedef struct packed {
        logic              zero;
        logic [1:0]        dyn;
        t_norm             norm;
        logic              sx;
        logic              sy;
        logic [MAG_W-1:0]  px_mag;
        logic [MAG_W-1:0]  py_mag;
        logic [SOFT_W-1:0] softness;
        logic [MASS_W-1:0] ma;
        logic [MASS_W-1:0] mb;
        logic              hit;
    } t_job;

    typedef struct packed {
        logic           hit;
        logic           zero;
        logic [1:0]     dyn;
        t_norm          norm;
        logic           sx;
        logic           sy;
        logic [C_W-1:0] cx;
        logic [C_W-1:0] cy;
    } t_meta;

    function automatic logic [SCALE_W-1:0] nx_of(t_norm n);
        unique case (n)
            NORM_X:    return SCALE_ONE;
            NORM_Y:    return '0;
            NORM_DIAG: return DIAG_Q15;
            default:   return '0;
        endcase
    endfunction

    function automatic logic [SCALE_W-1:0] ny_of(t_norm n);
        unique case (n)
            NORM_X:    return '0;
            NORM_Y:    return SCALE_ONE;
            NORM_DIAG: return DIAG_Q15;
            default:   return '0;
        endcase
    endfunction

    // sign-magnitude to saturated two's complement move
    function automatic logic [MOVE_W-1:0] sat_move(logic neg, logic [C_W-1:0] mag);
        if (!neg) begin
            if (mag > C_W'(MOVE_MAX)) return MOVE_MAX;
            return mag[MOVE_W-1:0];
        end
        if (mag > C_W'(MOVE_MIN)) return MOVE_MIN;
        return MOVE_W'(-mag[MOVE_W-1:0]);
    endfunction

endpackage

@@ hw/rtl/aabbpc_front.sv @@
module aabbpc_front (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [aabbpc_pkg::EDGE_W-1:0]   i_a_min_x,
    input  logic signed [aabbpc_pkg::EDGE_W-1:0]   i_a_min_y,
    input  logic        [aabbpc_pkg::SIZE_W-1:0]   i_a_width,
    input  logic        [aabbpc_pkg::SIZE_W-1:0]   i_a_height,
    input  logic signed [aabbpc_pkg::EDGE_W-1:0]   i_b_min_x,
    input  logic signed [aabbpc_pkg::EDGE_W-1:0]   i_b_min_y,
    input  logic        [aabbpc_pkg::SIZE_W-1:0]   i_b_width,
    input  logic        [aabbpc_pkg::SIZE_W-1:0]   i_b_height,
    input  logic        [aabbpc_pkg::MASS_W-1:0]   i_a_mass,
    input  logic        [aabbpc_pkg::MASS_W-1:0]   i_b_mass,
    input  logic        [aabbpc_pkg::SOFT_W-1:0]   i_softness_mean,
    input  logic        [1:0]                      i_dynamic_pair,
    input  logic                                   i_full,
    output logic                                   o_push,
    output aabbpc_pkg::t_job                       o_job
);
    import aabbpc_pkg::*;

    logic signed [POS_W-1:0] ax, ay, bx, by, axr, ayt, bxr, byt, px, py;
    logic [MAG_W-1:0] px_mag, py_mag;
    logic             hit;
    logic             adv;
    t_job             n_job;
    t_job             r_job;
    logic             r_valid;

    always_comb begin
        ax  = POS_W'(i_a_min_x);
        ay  = POS_W'(i_a_min_y);
        bx  = POS_W'(i_b_min_x);
        by  = POS_W'(i_b_min_y);
        axr = ax + POS_W'(i_a_width);
        ayt = ay + POS_W'(i_a_height);
        bxr = bx + POS_W'(i_b_width);
        byt = by + POS_W'(i_b_height);
        hit = !(axr < bx || bxr < ax || ayt < by || byt < ay);
        px  = (ax <= bx) ? (bx - axr) : (bxr - ax);
        py  = (ay <= by) ? (by - ayt) : (byt - ay);
        px_mag = px[POS_W-1] ? MAG_W'(-px) : MAG_W'(px);
        py_mag = py[POS_W-1] ? MAG_W'(-py) : MAG_W'(py);

        n_job.hit      = hit;
        n_job.zero     = !hit || px == '0 || py == '0;
        n_job.dyn      = i_dynamic_pair;
        n_job.sx       = px[POS_W-1];
        n_job.sy       = py[POS_W-1];
        n_job.px_mag   = px_mag;
        n_job.py_mag   = py_mag;
        n_job.softness = i_softness_mean;
        n_job.ma       = i_a_mass;
        n_job.mb       = i_b_mass;
        if (px_mag < py_mag) begin
            n_job.norm = NORM_X;
        end else if (px_mag > py_mag) begin
            n_job.norm = NORM_Y;
        end else begin
            n_job.norm = NORM_DIAG;
        end
    end

    assign adv     = !r_valid || !i_full;
    assign o_stall = r_valid && i_full;
    assign o_push  = r_valid && !i_full;
    assign o_job   = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_job <= n_job;
        end
    end

endmodule

@@ hw/rtl/aabbpc_queue.sv @@
module aabbpc_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  aabbpc_pkg::t_job  i_job,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output aabbpc_pkg::t_job  o_job
);
    import aabbpc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

@@ hw/rtl/aabbpc_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, round half up
// on the magnitude. Quotient is known to fit C_W bits.
module aabbpc_div (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [aabbpc_pkg::PROD_W-1:0]      i_num,
    input  logic [aabbpc_pkg::DEN_W-1:0]       i_den,
    output logic [aabbpc_pkg::C_W-1:0]         o_quot
);
    import aabbpc_pkg::*;

    logic [DEN_W-1:0] r_rem [C_W+1];
    logic [C_W-1:0]   r_lo  [C_W+1];
    logic [C_W-1:0]   r_q   [C_W+1];
    logic [DEN_W-1:0] r_den [C_W+1];
    logic [PROD_W:0]  n_num;

    assign n_num = (PROD_W+1)'(i_num) + (PROD_W+1)'(i_den >> 1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_num[PROD_W:C_W];
            r_lo[0]  <= n_num[C_W-1:0];
            r_q[0]   <= '0;
            r_den[0] <= i_den;
        end
    end

    for (genvar k = 0; k < C_W; k++) begin : g_step
        logic [DEN_W:0] t;
        logic           ge;

        always_comb begin
            t  = {r_rem[k], r_lo[k][C_W-1]};
            ge = t >= {1'b0, r_den[k]};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= ge ? DEN_W'(t - {1'b0, r_den[k]}) : t[DEN_W-1:0];
                r_lo[k+1]  <= r_lo[k] << 1;
                r_q[k+1]   <= {r_q[k][C_W-2:0], ge};
                r_den[k+1] <= r_den[k];
            end
        end
    end

    assign o_quot = r_q[C_W];

endmodule

@@ hw/rtl/aabbpc_back.sv @@
module aabbpc_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_empty,
    input  aabbpc_pkg::t_job                     i_job,
    output logic                                 o_pop,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic                                 o_hit,
    output logic signed [aabbpc_pkg::MOVE_W-1:0] o_a_move_x,
    output logic signed [aabbpc_pkg::MOVE_W-1:0] o_a_move_y,
    output logic signed [aabbpc_pkg::MOVE_W-1:0] o_b_move_x,
    output logic signed [aabbpc_pkg::MOVE_W-1:0] o_b_move_y,
    output logic        [aabbpc_pkg::SCALE_W-1:0] o_vertical_velocity_scale
);
    import aabbpc_pkg::*;

    localparam int M1_W = MAG_W + SOFT_W;       // 37
    localparam int YP_W = MAG_W + SCALE_W;      // 41
    localparam int LO_W = M1_W / 2;             // 18
    localparam int HI_W = M1_W - LO_W;          // 19
    localparam int M2_W = M1_W + SCALE_W;       // 53

    logic en;

    // stage 1: push times softness, y push times normal
    logic              r1_v;
    t_meta             r1_meta;
    logic [M1_W-1:0]   r1_m1;
    logic [YP_W-1:0]   r1_yp;
    logic [MASS_W-1:0] r1_ma, r1_mb;
    t_meta             n1_meta;

    // stage 2: x product split in two partial products, y rounded
    logic                    r2_v;
    t_meta                   r2_meta;
    logic [HI_W+SCALE_W-1:0] r2_phi;
    logic [LO_W+SCALE_W-1:0] r2_plo;
    logic [MASS_W-1:0]       r2_ma, r2_mb;
    logic [YP_W:0]           n2_ysum;
    logic [SCALE_W-1:0]      n2_nx;
    t_meta                   n2_meta;

    // stage 3: x rounded
    logic              r3_v;
    t_meta             r3_meta;
    logic [MASS_W-1:0] r3_ma, r3_mb;
    logic [M2_W-1:0]   n3_sum;
    t_meta             n3_meta;

    // stage 4: dividends and mass sum
    logic              r4_v;
    t_meta             r4_meta;
    logic [PROD_W-1:0] r4_p [4];
    logic [DEN_W-1:0]  r4_sum;
    logic [DEN_W-1:0]  n4_sum;

    logic [C_W-1:0]    quot [4];
    logic              r_vd [DIV_LAT];
    t_meta             r_md [DIV_LAT];
    t_meta             md;

    logic                r_out_v;
    logic                r_hit;
    logic [MOVE_W-1:0]   r_amx, r_amy, r_bmx, r_bmy;
    logic [SCALE_W-1:0]  r_vs;
    logic [MOVE_W-1:0]   n_amx, n_amy, n_bmx, n_bmy;
    logic [SCALE_W-1:0]  n_vs;

    assign en    = !(r_out_v && i_stall);
    assign o_pop = en && !i_empty;

    always_comb begin
        n1_meta.hit  = i_job.hit;
        n1_meta.zero = i_job.zero;
        n1_meta.dyn  = i_job.dyn;
        n1_meta.norm = i_job.norm;
        n1_meta.sx   = i_job.sx;
        n1_meta.sy   = i_job.sy;
        n1_meta.cx   = '0;
        n1_meta.cy   = '0;
        n2_nx   = nx_of(r1_meta.norm);
        n2_ysum = (YP_W+1)'(r1_yp) + (YP_W+1)'(1 << 14);
        n2_meta    = r1_meta;
        n2_meta.cy = C_W'(n2_ysum[YP_W:15]);
        n3_sum  = {r2_phi, LO_W'(0)} + M2_W'(r2_plo) + M2_W'(1 << 22);
        n3_meta    = r2_meta;
        n3_meta.cx = n3_sum[M2_W-1:23];
        n4_sum  = DEN_W'(r3_ma) + DEN_W'(r3_mb);
        if (n4_sum == '0) begin
            n4_sum = MASS_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (en) begin
            r1_v <= !i_empty;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_meta <= n1_meta;
            r1_m1   <= i_job.px_mag * i_job.softness;
            r1_yp   <= i_job.py_mag * ny_of(i_job.norm);
            r1_ma   <= i_job.ma;
            r1_mb   <= i_job.mb;

            r2_meta    <= n2_meta;
            r2_phi     <= r1_m1[M1_W-1:LO_W] * n2_nx;
            r2_plo     <= r1_m1[LO_W-1:0] * n2_nx;
            r2_ma      <= r1_ma;
            r2_mb      <= r1_mb;

            r3_meta    <= n3_meta;
            r3_ma      <= r2_ma;
            r3_mb      <= r2_mb;

            r4_meta <= r3_meta;
            r4_p[0] <= r3_meta.cx * r3_mb;
            r4_p[1] <= r3_meta.cy * r3_mb;
            r4_p[2] <= r3_meta.cx * r3_ma;
            r4_p[3] <= r3_meta.cy * r3_ma;
            r4_sum  <= n4_sum;
        end
    end

    // lanes: A x, A y, B x, B y
    for (genvar k = 0; k < 4; k++) begin : g_div
        aabbpc_div u_div (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_num  (r4_p[k]),
            .i_den  (r4_sum),
            .o_quot (quot[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) begin
                r_vd[i] <= 1'b0;
            end
        end else if (en) begin
            r_vd[0] <= r4_v;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_vd[i] <= r_vd[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_md[0] <= r4_meta;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_md[i] <= r_md[i-1];
            end
        end
    end

    assign md = r_md[DIV_LAT-1];

    always_comb begin
        n_amx = '0;
        n_amy = '0;
        n_bmx = '0;
        n_bmy = '0;
        n_vs  = SCALE_ONE;
        if (!md.zero) begin
            if (md.dyn == 2'b11) begin
                n_amx = sat_move(md.sx, quot[0]);
                n_amy = sat_move(md.sy, quot[1]);
                n_bmx = sat_move(!md.sx, quot[2]);
                n_bmy = sat_move(!md.sy, quot[3]);
            end else begin
                n_vs = nx_of(md.norm);
                if (md.dyn[0]) begin
                    n_amx = sat_move(md.sx, md.cx);
                    n_amy = sat_move(md.sy, md.cy);
                end
                if (md.dyn[1]) begin
                    n_bmx = sat_move(md.sx, md.cx);
                    n_bmy = sat_move(md.sy, md.cy);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_vd[DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit <= md.hit;
            r_amx <= n_amx;
            r_amy <= n_amy;
            r_bmx <= n_bmx;
            r_bmy <= n_bmy;
            r_vs  <= n_vs;
        end
    end

    assign o_valid                   = r_out_v;
    assign o_hit                     = r_hit;
    assign o_a_move_x                = r_amx;
    assign o_a_move_y                = r_amy;
    assign o_b_move_x                = r_bmx;
    assign o_b_move_y                = r_bmy;
    assign o_vertical_velocity_scale = r_vs;

endmodule

@@ hw/rtl/aabb_pair_collision_correction_core.sv @@
// Box pair push-out: one pair of boxes in, one correction word out.
// Input channel: i_valid with the box, mass, softness and dynamic fields;
// the word is taken at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid with hit, four saturated moves and the vertical
// velocity factor; the word leaves at an edge with o_valid high and
// i_stall low. While i_stall holds, the output word stays put.
// Throughput: one word per cycle while neither side stalls. Path from
// acceptance to o_valid: front register, queue, four multiply and rounding
// stages, the one-bit-per-stage mass dividers, output reg.
// A front stage classifies the pair and feeds a QUEUE_DEPTH-entry queue;
// the back pipeline drains it and freezes as a whole while the output
// word is stalled, so o_stall rises only once the queue is full.
// Reset (i_rst_n low, synchronous) empties the queue and all stages;
// o_valid and o_stall are low afterwards.
module aabb_pair_collision_correction_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [aabbpc_pkg::EDGE_W-1:0]  i_a_min_x,
    input  logic signed [aabbpc_pkg::EDGE_W-1:0]  i_a_min_y,
    input  logic        [aabbpc_pkg::SIZE_W-1:0]  i_a_width,
    input  logic        [aabbpc_pkg::SIZE_W-1:0]  i_a_height,
    input  logic signed [aabbpc_pkg::EDGE_W-1:0]  i_b_min_x,
    input  logic signed [aabbpc_pkg::EDGE_W-1:0]  i_b_min_y,
    input  logic        [aabbpc_pkg::SIZE_W-1:0]  i_b_width,
    input  logic        [aabbpc_pkg::SIZE_W-1:0]  i_b_height,
    input  logic        [aabbpc_pkg::MASS_W-1:0]  i_a_mass,
    input  logic        [aabbpc_pkg::MASS_W-1:0]  i_b_mass,
    input  logic        [aabbpc_pkg::SOFT_W-1:0]  i_softness_mean,
    input  logic        [1:0]                     i_dynamic_pair,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic                                  o_hit,
    output logic signed [aabbpc_pkg::MOVE_W-1:0]  o_a_move_x,
    output logic signed [aabbpc_pkg::MOVE_W-1:0]  o_a_move_y,
    output logic signed [aabbpc_pkg::MOVE_W-1:0]  o_b_move_x,
    output logic signed [aabbpc_pkg::MOVE_W-1:0]  o_b_move_y,
    output logic        [aabbpc_pkg::SCALE_W-1:0] o_vertical_velocity_scale
);
    import aabbpc_pkg::*;

    logic push, full, pop, empty;
    t_job f_job, q_job;

    aabbpc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_a_min_x       (i_a_min_x),
        .i_a_min_y       (i_a_min_y),
        .i_a_width       (i_a_width),
        .i_a_height      (i_a_height),
        .i_b_min_x       (i_b_min_x),
        .i_b_min_y       (i_b_min_y),
        .i_b_width       (i_b_width),
        .i_b_height      (i_b_height),
        .i_a_mass        (i_a_mass),
        .i_b_mass        (i_b_mass),
        .i_softness_mean (i_softness_mean),
        .i_dynamic_pair  (i_dynamic_pair),
        .i_full          (full),
        .o_push          (push),
        .o_job           (f_job)
    );

    aabbpc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (q_job)
    );

    aabbpc_back u_back (
        .i_clk                     (i_clk),
        .i_rst_n                   (i_rst_n),
        .i_empty                   (empty),
        .i_job                     (q_job),
        .o_pop                     (pop),
        .o_valid                   (o_valid),
        .i_stall                   (i_stall),
        .o_hit                     (o_hit),
        .o_a_move_x                (o_a_move_x),
        .o_a_move_y                (o_a_move_y),
        .o_b_move_x                (o_b_move_x),
        .o_b_move_y                (o_b_move_y),
        .o_vertical_velocity_scale (o_vertical_velocity_scale)
    );

endmodule

@@ hw/rtl/aabbpc_checker.sv @@
`include "aabb_pair_collision_correction_core_assert.svh"

module aabbpc_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_valid,
    input logic                                  o_stall,
    input logic signed [aabbpc_pkg::EDGE_W-1:0]  i_a_min_x,
    input logic signed [aabbpc_pkg::EDGE_W-1:0]  i_a_min_y,
    input logic        [aabbpc_pkg::SIZE_W-1:0]  i_a_width,
    input logic        [aabbpc_pkg::SIZE_W-1:0]  i_a_height,
    input logic signed [aabbpc_pkg::EDGE_W-1:0]  i_b_min_x,
    input logic signed [aabbpc_pkg::EDGE_W-1:0]  i_b_min_y,
    input logic        [aabbpc_pkg::SIZE_W-1:0]  i_b_width,
    input logic        [aabbpc_pkg::SIZE_W-1:0]  i_b_height,
    input logic        [aabbpc_pkg::MASS_W-1:0]  i_a_mass,
    input logic        [aabbpc_pkg::MASS_W-1:0]  i_b_mass,
    input logic        [aabbpc_pkg::SOFT_W-1:0]  i_softness_mean,
    input logic        [1:0]                     i_dynamic_pair,
    input logic                                  o_valid,
    input logic                                  i_stall,
    input logic                                  o_hit,
    input logic signed [aabbpc_pkg::MOVE_W-1:0]  o_a_move_x,
    input logic signed [aabbpc_pkg::MOVE_W-1:0]  o_a_move_y,
    input logic signed [aabbpc_pkg::MOVE_W-1:0]  o_b_move_x,
    input logic signed [aabbpc_pkg::MOVE_W-1:0]  o_b_move_y,
    input logic        [aabbpc_pkg::SCALE_W-1:0] o_vertical_velocity_scale
);
    import aabbpc_pkg::*;

    // a stalled word stays valid
    `AST_NEXT(a_out_hold, o_valid && i_stall, o_valid)

    // and keeps its payload
    `AST_NEXT(a_out_stable, o_valid && i_stall, $stable(o_hit) && $stable(o_a_move_x) && $stable(o_a_move_y) && $stable(o_b_move_x) && $stable(o_b_move_y) && $stable(o_vertical_velocity_scale))

    // a miss never moves anything
    `AST_IMPL(a_miss_zero, o_valid && !o_hit, o_a_move_x == '0 && o_a_move_y == '0 && o_b_move_x == '0 && o_b_move_y == '0 && o_vertical_velocity_scale == SCALE_ONE)

    // velocity factor is one of the normal's x values
    `AST_IMPL(a_vscale_legal, o_valid, o_vertical_velocity_scale == SCALE_ONE || o_vertical_velocity_scale == DIAG_Q15 || o_vertical_velocity_scale == '0)

endmodule

bind aabb_pair_collision_correction_core aabbpc_checker u_aabbpc_checker (.*);

@@ bench/aabb_pair_collision_correction_core_tb.sv @@
module aabb_pair_collision_correction_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aabbpc_pkg::*;

    localparam logic [1:0] DYN_NONE = 2'b00;
    localparam logic [1:0] DYN_A    = 2'b01;
    localparam logic [1:0] DYN_B    = 2'b10;
    localparam logic [1:0] DYN_BOTH = 2'b11;
    localparam longint MV_MAX = 16777215;
    localparam longint MV_MIN = -16777216;
    localparam longint NX_ONE = 32768;
    localparam longint NX_DIAG = 23170;
    localparam longint MASS_UNIT = 256;
    localparam int N_RANDOM = 2000;

    typedef struct {
        logic signed [EDGE_W-1:0] ax, ay, bx, by;
        logic [SIZE_W-1:0] aw, ah, bw, bh;
        logic [MASS_W-1:0] ma, mb;
        logic [SOFT_W-1:0] softness;
        logic [1:0] dyn;
    } t_pair;

    typedef struct {
        logic hit;
        logic [MOVE_W-1:0] amx, amy, bmx, bmy;
        logic [SCALE_W-1:0] vscale;
    } t_corr;

    class corr_scoreboard;
        t_corr expected_q[$];
        int errors = 0;

        function automatic longint round_shift(longint v, int sh);
            longint mag, q;
            mag = (v < 0) ? -v : v;
            q = (mag + (longint'(1) << (sh - 1))) >>> sh;
            return (v < 0) ? -q : q;
        endfunction

        function automatic longint round_div(longint n, longint d);
            longint mag, q;
            mag = (n < 0) ? -n : n;
            q = (mag + d / 2) / d;
            return (n < 0) ? -q : q;
        endfunction

        function automatic logic [MOVE_W-1:0] clamp(longint v);
            if (v > MV_MAX) v = MV_MAX;
            if (v < MV_MIN) v = MV_MIN;
            return v[MOVE_W-1:0];
        endfunction

        function automatic t_corr push_out(t_pair p);
            longint ax, ay, bx, by, axr, ayt, bxr, byt, px, py, nx, ny, cx, cy, s;
            longint amx, amy, bmx, bmy, vs, apx, apy;
            t_corr r;
            ax = longint'(p.ax); ay = longint'(p.ay);
            bx = longint'(p.bx); by = longint'(p.by);
            axr = ax + longint'(p.aw); ayt = ay + longint'(p.ah);
            bxr = bx + longint'(p.bw); byt = by + longint'(p.bh);
            amx = 0; amy = 0; bmx = 0; bmy = 0; vs = NX_ONE;
            r.hit = !(axr < bx || bxr < ax || ayt < by || byt < ay);
            if (r.hit) begin
                px = (ax <= bx) ? (bx - axr) : (bxr - ax);
                py = (ay <= by) ? (by - ayt) : (byt - ay);
                if (px != 0 && py != 0) begin
                    apx = (px < 0) ? -px : px;
                    apy = (py < 0) ? -py : py;
                    if (apx < apy) begin
                        nx = NX_ONE; ny = 0;
                    end else if (apx > apy) begin
                        nx = 0; ny = NX_ONE;
                    end else begin
                        nx = NX_DIAG; ny = NX_DIAG;
                    end
                    cx = round_shift(px * longint'(p.softness) * nx, 23);
                    cy = round_shift(py * ny, 15);
                    if (p.dyn == DYN_BOTH) begin
                        s = longint'(p.ma) + longint'(p.mb);
                        if (s == 0) s = MASS_UNIT;
                        amx = round_div(cx * longint'(p.mb), s);
                        amy = round_div(cy * longint'(p.mb), s);
                        bmx = -round_div(cx * longint'(p.ma), s);
                        bmy = -round_div(cy * longint'(p.ma), s);
                    end else begin
                        vs = nx;
                        if (p.dyn[0]) begin amx = cx; amy = cy; end
                        if (p.dyn[1]) begin bmx = cx; bmy = cy; end
                    end
                end
            end
            r.amx = clamp(amx); r.amy = clamp(amy);
            r.bmx = clamp(bmx); r.bmy = clamp(bmy);
            r.vscale = vs[SCALE_W-1:0];
            return r;
        endfunction

        function void note_pair(t_pair p);
            expected_q.push_back(push_out(p));
        endfunction

        function void check_corr(t_corr a);
            t_corr e;
            if (expected_q.size() == 0) begin
                $error("unexpected output word");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (a.hit !== e.hit) begin
                $error("hit exp %0d got %0d", e.hit, a.hit); errors++;
            end
            if (a.amx !== e.amx) begin
                $error("a_move_x exp %0d got %0d", $signed(e.amx), $signed(a.amx)); errors++;
            end
            if (a.amy !== e.amy) begin
                $error("a_move_y exp %0d got %0d", $signed(e.amy), $signed(a.amy)); errors++;
            end
            if (a.bmx !== e.bmx) begin
                $error("b_move_x exp %0d got %0d", $signed(e.bmx), $signed(a.bmx)); errors++;
            end
            if (a.bmy !== e.bmy) begin
                $error("b_move_y exp %0d got %0d", $signed(e.bmy), $signed(a.bmy)); errors++;
            end
            if (a.vscale !== e.vscale) begin
                $error("vertical_velocity_scale exp %0d got %0d", e.vscale, a.vscale);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, i_valid, o_stall, o_valid, i_stall, o_hit;
    logic signed [EDGE_W-1:0] i_a_min_x, i_a_min_y, i_b_min_x, i_b_min_y;
    logic [SIZE_W-1:0] i_a_width, i_a_height, i_b_width, i_b_height;
    logic [MASS_W-1:0] i_a_mass, i_b_mass;
    logic [SOFT_W-1:0] i_softness_mean;
    logic [1:0] i_dynamic_pair;
    logic signed [MOVE_W-1:0] o_a_move_x, o_a_move_y, o_b_move_x, o_b_move_y;
    logic [SCALE_W-1:0] o_vertical_velocity_scale;

    aabb_pair_collision_correction_core DUT (.*);

    corr_scoreboard sb = new();
    bit quiet = 0;     // no idling on either side
    bit hold_req = 0;  // receiver long hold-off
    t_pair dir_q[$];

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("TEST FAILED");
        $finish;
    end

    function automatic t_pair mk(int ax, int ay, int aw, int ah, int bx, int by,
                                 int bw, int bh, int ma, int mb, int softness,
                                 logic [1:0] dyn);
        t_pair p;
        p.ax = EDGE_W'(ax); p.ay = EDGE_W'(ay);
        p.aw = SIZE_W'(aw); p.ah = SIZE_W'(ah);
        p.bx = EDGE_W'(bx); p.by = EDGE_W'(by);
        p.bw = SIZE_W'(bw); p.bh = SIZE_W'(bh);
        p.ma = MASS_W'(ma); p.mb = MASS_W'(mb);
        p.softness = SOFT_W'(softness); p.dyn = dyn;
        return p;
    endfunction

    function automatic t_pair rand_pair();
        t_pair p;
        int sel, ox, oy;
        p.ma = MASS_W'($urandom); p.mb = MASS_W'($urandom);
        p.softness = SOFT_W'($urandom); p.dyn = 2'($urandom);
        if ($urandom_range(0, 19) == 0) begin p.ma = '0; p.mb = '0; end
        sel = int'($urandom_range(0, 9));
        if (sel < 3) begin
            // anything goes, full width fields
            p.ax = EDGE_W'($urandom); p.ay = EDGE_W'($urandom);
            p.bx = EDGE_W'($urandom); p.by = EDGE_W'($urandom);
            p.aw = SIZE_W'($urandom); p.ah = SIZE_W'($urandom);
            p.bw = SIZE_W'($urandom); p.bh = SIZE_W'($urandom);
        end else begin
            p.aw = SIZE_W'($urandom_range(0, 4096)); p.ah = SIZE_W'($urandom_range(0, 4096));
            p.bw = SIZE_W'($urandom_range(0, 4096)); p.bh = SIZE_W'($urandom_range(0, 4096));
            p.ax = EDGE_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
            p.ay = EDGE_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
            ox = int'($urandom_range(0, int'(p.aw) + int'(p.bw) + 4)) - int'(p.bw) - 2;
            oy = int'($urandom_range(0, int'(p.ah) + int'(p.bh) + 4)) - int'(p.bh) - 2;
            if (sel == 9) begin
                // equal pushes on both axes
                p.ah = p.aw; p.bh = p.bw; oy = ox;
            end
            p.bx = EDGE_W'(int'(p.ax) + ox); p.by = EDGE_W'(int'(p.ay) + oy);
        end
        return p;
    endfunction

    task automatic send_all();
        t_pair p;
        int n, gap;
        n = dir_q.size() + N_RANDOM;
        for (int k = 0; k < n; k++) begin
            p = (k < dir_q.size()) ? dir_q[k] : rand_pair();
            quiet = (k >= 800 && k < 1100);
            if (k == 1300) hold_req = 1;
            // an idle gap before roughly 43 in a hundred pairs
            gap = (!quiet && $urandom_range(0, 99) < 43) ? 1 : 0;
            if (gap > 0) begin
                i_valid <= 0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid <= 1;
            i_a_min_x <= p.ax; i_a_min_y <= p.ay; i_a_width <= p.aw; i_a_height <= p.ah;
            i_b_min_x <= p.bx; i_b_min_y <= p.by; i_b_width <= p.bw; i_b_height <= p.bh;
            i_a_mass <= p.ma; i_b_mass <= p.mb; i_softness_mean <= p.softness;
            i_dynamic_pair <= p.dyn;
            do @(posedge i_clk); while (o_stall);
            sb.note_pair(p);
        end
        i_valid <= 0;
    endtask

    // receiver: checks words and drives stall
    initial begin
        t_corr a;
        int hold;
        hold = 0;
        i_stall = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                a.hit = o_hit; a.amx = o_a_move_x; a.amy = o_a_move_y;
                a.bmx = o_b_move_x; a.bmy = o_b_move_y; a.vscale = o_vertical_velocity_scale;
                sb.check_corr(a);
            end
            if (hold_req) begin
                hold_req = 0;
                hold = 300;
            end
            if (hold > 0) begin
                hold--;
                i_stall <= 1;
            end else begin
                i_stall <= !quiet && ($urandom_range(0, 99) < 30);
            end
        end
    end

    initial begin
        i_rst_n = 0; i_valid = 0;
        i_a_min_x = 0; i_a_min_y = 0; i_a_width = 0; i_a_height = 0;
        i_b_min_x = 0; i_b_min_y = 0; i_b_width = 0; i_b_height = 0;
        i_a_mass = 0; i_b_mass = 0; i_softness_mean = 0; i_dynamic_pair = 0;
        // directed pairs
        dir_q.push_back(mk(0, 0, 256, 256, 128, 128, 256, 256, 256, 256, 256, DYN_BOTH));
        dir_q.push_back(mk(0, 0, 256, 256, 128, 128, 256, 256, 256, 256, 256, DYN_A));
        dir_q.push_back(mk(0, 0, 256, 512, 128, 0, 256, 512, 100, 300, 4095, DYN_B));
        dir_q.push_back(mk(0, 0, 512, 256, 0, 128, 512, 256, 100, 300, 200, DYN_A));
        dir_q.push_back(mk(0, 0, 256, 256, 256, 100, 256, 256, 256, 256, 256, DYN_BOTH));
        dir_q.push_back(mk(0, 0, 256, 256, 257, 0, 256, 256, 256, 256, 256, DYN_BOTH));
        dir_q.push_back(mk(0, 0, 256, 256, 100, 100, 50, 50, 0, 0, 256, DYN_BOTH));
        dir_q.push_back(mk(0, 0, 256, 256, 100, 10, 50, 500, 7, 3, 999, DYN_NONE));
        dir_q.push_back(mk(-8388608, -8388608, 8388607, 8388607, 8388607, 8388607,
                           8388607, 8388607, 65535, 65535, 4095, DYN_BOTH));
        dir_q.push_back(mk(-8388608, -8388608, 8388607, 8388607, -8388608, -4000000,
                           8388607, 8388607, 65535, 0, 4095, DYN_A));
        dir_q.push_back(mk(-8388608, -8388608, 8388607, 8388607, -4000000, -8388608,
                           8388607, 8388607, 0, 65535, 4095, DYN_B));
        dir_q.push_back(mk(8388607, 8388607, 0, 0, 8388607, 8388607, 0, 0,
                           65535, 65535, 4095, DYN_BOTH));
        dir_q.push_back(mk(-8388608, 0, 8388607, 8388607, 8388000, 10, 8388607, 100,
                           65535, 1, 4095, DYN_BOTH));
        dir_q.push_back(mk(500, 500, 256, 256, 0, 0, 600, 600, 1, 65535, 4095, DYN_BOTH));
        dir_q.push_back(mk(0, 0, 3, 3, 1, 1, 3, 3, 1, 2, 1, DYN_BOTH));
        dir_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, DYN_NONE));
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send_all();
        while (sb.expected_q.size() > 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/aabbpc_pkg.sv
hw/rtl/aabbpc_front.sv
hw/rtl/aabbpc_queue.sv
hw/rtl/aabbpc_div.sv
hw/rtl/aabbpc_back.sv
hw/rtl/aabb_pair_collision_correction_core.sv
hw/rtl/aabbpc_checker.sv
bench/aabb_pair_collision_correction_core_tb.sv
